[rtl/core/r2h_pkg.sv]
// Shared types, constants and width helpers for the RGB to HSV converter.
// No dependencies; every other file in rtl/core imports this package.
package r2h_pkg;

    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 6;
    localparam int QUEUE_DEPTH           = 2;

    // Hue sector, chosen by which channel holds the maximum.
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Classification that travels with each word from front to back.
    typedef struct packed {
        t_sector sector;
        logic    neg;       // signed difference is negative
        logic    sat_zero;  // maximum is zero
        logic    hue_zero;  // delta is zero
    } t_ctl;

    localparam int CTL_BITS = $bits(t_ctl);

    // Hue units for 60 degrees.
    function automatic int f_h60(input int hfb);
        return 60 * (2 ** hfb);
    endfunction

    // Width of the hue result, enough for 0 .. 360 degrees exclusive.
    function automatic int f_hue_bits(input int hfb);
        return $clog2(360 * (2 ** hfb));
    endfunction

    // Width of the hue quotient, which never exceeds one 60 degree step.
    function automatic int f_h60_bits(input int hfb);
        return $clog2(f_h60(hfb) + 1);
    endfunction

    // Quotient bits of both dividers, so their pipelines line up.
    function automatic int f_quo_bits(input int cb, input int hfb);
        return (cb > f_h60_bits(hfb)) ? cb : f_h60_bits(hfb);
    endfunction

endpackage

[rtl/core/r2h_front.sv]
// Front stage: accepts a pixel, finds max, min and delta, picks the hue sector
// and forms both dividends. Holds one classified word. Depends on r2h_pkg.
module r2h_front import r2h_pkg::*; #(
    parameter int CHANNEL_BITS      = CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF,
    localparam int SAT_NW = 2 * CHANNEL_BITS,
    localparam int HUE_NW = CHANNEL_BITS + f_h60_bits(HUE_FRACTION_BITS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    input  logic                    i_q_full,
    output logic                    o_push,
    output t_ctl                    o_ctl,
    output logic [CHANNEL_BITS-1:0] o_max,
    output logic [CHANNEL_BITS-1:0] o_delta,
    output logic [SAT_NW-1:0]       o_sat_num,
    output logic [HUE_NW-1:0]       o_hue_num
);

    localparam int H60 = f_h60(HUE_FRACTION_BITS);

    logic                    r_fv;
    t_ctl                    r_ctl;
    logic [CHANNEL_BITS-1:0] r_max;
    logic [CHANNEL_BITS-1:0] r_delta;
    logic [SAT_NW-1:0]       r_sat_num;
    logic [HUE_NW-1:0]       r_hue_num;

    logic                    w_load;
    logic [CHANNEL_BITS-1:0] w_max;
    logic [CHANNEL_BITS-1:0] w_min;
    logic [CHANNEL_BITS-1:0] w_delta;
    logic [CHANNEL_BITS-1:0] w_pos;
    logic [CHANNEL_BITS-1:0] w_sub;
    logic [CHANNEL_BITS-1:0] w_mag;
    t_ctl                    w_ctl;

    assign o_stall = r_fv && i_q_full;
    assign o_push  = r_fv && !i_q_full;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        w_max = i_red;
        if (i_green > w_max) w_max = i_green;
        if (i_blue > w_max)  w_max = i_blue;
        w_min = i_red;
        if (i_green < w_min) w_min = i_green;
        if (i_blue < w_min)  w_min = i_blue;
        w_delta = w_max - w_min;

        // Ties on the maximum go to red first, then green.
        if (i_red == w_max) begin
            w_ctl.sector = SEC_RED;
            w_pos = i_green;
            w_sub = i_blue;
        end else if (i_green == w_max) begin
            w_ctl.sector = SEC_GREEN;
            w_pos = i_blue;
            w_sub = i_red;
        end else begin
            w_ctl.sector = SEC_BLUE;
            w_pos = i_red;
            w_sub = i_green;
        end
        w_ctl.neg      = w_pos < w_sub;
        w_mag          = w_ctl.neg ? (w_sub - w_pos) : (w_pos - w_sub);
        w_ctl.sat_zero = w_max == '0;
        w_ctl.hue_zero = w_delta == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_load) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ctl     <= w_ctl;
            r_max     <= w_max;
            r_delta   <= w_delta;
            // Full scale times delta, done as a shift and a subtract.
            r_sat_num <= (SAT_NW'(w_delta) << CHANNEL_BITS) - SAT_NW'(w_delta);
            r_hue_num <= HUE_NW'(w_mag) * HUE_NW'(H60);
        end
    end

    assign o_ctl     = r_ctl;
    assign o_max     = r_max;
    assign o_delta   = r_delta;
    assign o_sat_num = r_sat_num;
    assign o_hue_num = r_hue_num;

endmodule

[rtl/core/r2h_queue.sv]
// Short first-in first-out queue between the front and back stages.
// Generic in word width. Depends on r2h_pkg for its depth.
module r2h_queue import r2h_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nempty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_pop;

    assign o_full   = r_cnt == CW'(QUEUE_DEPTH);
    assign o_nempty = r_cnt != '0;
    assign w_pop    = i_pop && o_nempty;
    assign o_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/core/r2h_div.sv]
// Pipelined restoring divider, one quotient bit per stage, one word per cycle while i_en
// is high. The dividend must be below the divisor shifted up by QW. Depends on r2h_pkg.
module r2h_div import r2h_pkg::*; #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [RW-1:0] w_trial;
        logic          w_fit;

        if (k == 0) begin : g_first
            assign w_rem_in = RW'(i_num);
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_trial = RW'(w_den_in) << (QW - 1 - k);
        assign w_fit   = w_rem_in >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= w_fit ? (w_quo_in | (QW'(1) << (QW - 1 - k))) : w_quo_in;
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_fit ? (w_rem_in - w_trial) : w_rem_in;
                    r_den[k] <= w_den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

[rtl/core/r2h_back.sv]
// Back stage: runs the saturation and hue divisions side by side, rebuilds
// the hue from sector and quotient, and holds the output word. Uses r2h_div.
module r2h_back import r2h_pkg::*; #(
    parameter int CHANNEL_BITS      = CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF,
    localparam int SAT_NW   = 2 * CHANNEL_BITS,
    localparam int HUE_NW   = CHANNEL_BITS + f_h60_bits(HUE_FRACTION_BITS),
    localparam int HUE_BITS = f_hue_bits(HUE_FRACTION_BITS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_nempty,
    output logic                    o_pop,
    input  t_ctl                    i_ctl,
    input  logic [CHANNEL_BITS-1:0] i_max,
    input  logic [CHANNEL_BITS-1:0] i_delta,
    input  logic [SAT_NW-1:0]       i_sat_num,
    input  logic [HUE_NW-1:0]       i_hue_num,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [HUE_BITS-1:0]     o_hue,
    output logic [CHANNEL_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0] o_brightness
);

    localparam int QW     = f_quo_bits(CHANNEL_BITS, HUE_FRACTION_BITS);
    localparam int H60B   = f_h60_bits(HUE_FRACTION_BITS);
    localparam int SIDE_W = CTL_BITS + CHANNEL_BITS;
    localparam logic [HUE_BITS-1:0] C_H120 = HUE_BITS'(2 * f_h60(HUE_FRACTION_BITS));
    localparam logic [HUE_BITS-1:0] C_H240 = HUE_BITS'(4 * f_h60(HUE_FRACTION_BITS));
    localparam logic [HUE_BITS-1:0] C_H360 = HUE_BITS'(6 * f_h60(HUE_FRACTION_BITS));

    logic                    w_adv;
    logic [QW-1:0]           w_sat_quo;
    logic [QW-1:0]           w_hue_quo;
    logic                    r_vld  [QW];
    logic [SIDE_W-1:0]       r_side [QW];
    t_ctl                    w_ctl;
    logic [CHANNEL_BITS-1:0] w_max;
    logic [HUE_BITS-1:0]     w_q;
    logic [HUE_BITS-1:0]     w_base;
    logic [HUE_BITS-1:0]     w_hue;
    logic                    r_out_vld;
    logic [HUE_BITS-1:0]     r_hue;
    logic [CHANNEL_BITS-1:0] r_sat;
    logic [CHANNEL_BITS-1:0] r_bright;

    // The whole pipeline moves together unless the output word is held.
    assign w_adv = !(r_out_vld && i_stall);
    assign o_pop = w_adv;

    r2h_div #(
        .NW(SAT_NW),
        .DW(CHANNEL_BITS),
        .QW(QW)
    ) u_sat_div (
        .i_clk(i_clk),
        .i_en (w_adv),
        .i_num(i_sat_num),
        .i_den(i_max),
        .o_quo(w_sat_quo)
    );

    r2h_div #(
        .NW(HUE_NW),
        .DW(CHANNEL_BITS),
        .QW(QW)
    ) u_hue_div (
        .i_clk(i_clk),
        .i_en (w_adv),
        .i_num(i_hue_num),
        .i_den(i_delta),
        .o_quo(w_hue_quo)
    );

    for (genvar k = 0; k < QW; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k] <= (k == 0) ? i_q_nempty : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_side[k] <= (k == 0) ? {i_ctl, i_max} : r_side[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign {w_ctl, w_max} = r_side[QW-1];
    assign w_q = HUE_BITS'(w_hue_quo[H60B-1:0]);

    always_comb begin
        case (w_ctl.sector)
            SEC_RED:   w_base = '0;
            SEC_GREEN: w_base = C_H120;
            SEC_BLUE:  w_base = C_H240;
            default:   w_base = '0;
        endcase
        if (w_ctl.hue_zero) begin
            w_hue = '0;
        end else if (!w_ctl.neg) begin
            w_hue = w_base + w_q;
        end else if (w_ctl.sector == SEC_RED && w_q != '0) begin
            // A negative angle in the red sector wraps around the circle.
            w_hue = C_H360 - w_q;
        end else begin
            w_hue = w_base - w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hue    <= w_hue;
            r_sat    <= w_ctl.sat_zero ? '0 : w_sat_quo[CHANNEL_BITS-1:0];
            r_bright <= w_max;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule

[rtl/core/rgb_to_hsv_converter_unit.sv]
// Top level of the RGB to HSV converter: front stage, queue and back stage.
// Depends on r2h_pkg, r2h_front, r2h_queue, r2h_back and r2h_div.
//
// Converts one RGB pixel per clock, unless a stall holds the flow, to hue
// (in 1/2^HUE_FRACTION_BITS degree), saturation and value. A pixel is taken
// when i_valid is high and o_stall is low; a result word leaves when o_valid
// is high and i_stall is low. The block sustains one word per cycle while
// i_stall stays low. A pixel passes through the front stage register that
// classifies it, the queue, the pipelined dividers and the output register.
// A two-word queue between the front and back stages absorbs a held output
// without stalling the input at once.
module rgb_to_hsv_converter_unit import r2h_pkg::*; #(
    parameter int CHANNEL_BITS      = CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic [CHANNEL_BITS-1:0]                   i_red,
    input  logic [CHANNEL_BITS-1:0]                   i_green,
    input  logic [CHANNEL_BITS-1:0]                   i_blue,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic [f_hue_bits(HUE_FRACTION_BITS)-1:0]  o_hue,
    output logic [CHANNEL_BITS-1:0]                   o_saturation,
    output logic [CHANNEL_BITS-1:0]                   o_brightness
);

    localparam int SAT_NW = 2 * CHANNEL_BITS;
    localparam int HUE_NW = CHANNEL_BITS + f_h60_bits(HUE_FRACTION_BITS);
    localparam int Q_W    = CTL_BITS + 2 * CHANNEL_BITS + SAT_NW + HUE_NW;

    logic                    w_q_full;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_q_nempty;
    t_ctl                    w_f_ctl;
    logic [CHANNEL_BITS-1:0] w_f_max;
    logic [CHANNEL_BITS-1:0] w_f_delta;
    logic [SAT_NW-1:0]       w_f_sat_num;
    logic [HUE_NW-1:0]       w_f_hue_num;
    t_ctl                    w_b_ctl;
    logic [CHANNEL_BITS-1:0] w_b_max;
    logic [CHANNEL_BITS-1:0] w_b_delta;
    logic [SAT_NW-1:0]       w_b_sat_num;
    logic [HUE_NW-1:0]       w_b_hue_num;
    logic [Q_W-1:0]          w_q_in;
    logic [Q_W-1:0]          w_q_out;

    r2h_front #(
        .CHANNEL_BITS     (CHANNEL_BITS),
        .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_ctl    (w_f_ctl),
        .o_max    (w_f_max),
        .o_delta  (w_f_delta),
        .o_sat_num(w_f_sat_num),
        .o_hue_num(w_f_hue_num)
    );

    assign w_q_in = {w_f_ctl, w_f_max, w_f_delta, w_f_sat_num, w_f_hue_num};

    r2h_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_nempty(w_q_nempty),
        .o_data  (w_q_out)
    );

    assign {w_b_ctl, w_b_max, w_b_delta, w_b_sat_num, w_b_hue_num} = w_q_out;

    r2h_back #(
        .CHANNEL_BITS     (CHANNEL_BITS),
        .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_nempty  (w_q_nempty),
        .o_pop       (w_pop),
        .i_ctl       (w_b_ctl),
        .i_max       (w_b_max),
        .i_delta     (w_b_delta),
        .i_sat_num   (w_b_sat_num),
        .i_hue_num   (w_b_hue_num),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hue       (o_hue),
        .o_saturation(o_saturation),
        .o_brightness(o_brightness)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench for rgb_to_hsv_converter_unit: sends RGB words, predicts the HSV word
// of each accepted pixel and checks the results in order.
// Depends on r2h_pkg and the converter RTL under rtl/core.
module testbench;
    import r2h_pkg::*;

    localparam int CH_BITS        = CHANNEL_BITS_DEF;
    localparam int HUE_BITS       = f_hue_bits(HUE_FRACTION_BITS_DEF);
    localparam int CH_FULL        = (1 << CH_BITS) - 1;
    localparam int HUE_STEP       = 60 << HUE_FRACTION_BITS_DEF;
    localparam int HUE_TURN       = 360 << HUE_FRACTION_BITS_DEF;
    localparam int IDLE_PERCENT   = 15;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [CH_BITS-1:0]  sat;
        logic [CH_BITS-1:0]  val;
    } t_hsv_word;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    logic [CH_BITS-1:0]  i_red   = '0;
    logic [CH_BITS-1:0]  i_green = '0;
    logic [CH_BITS-1:0]  i_blue  = '0;
    logic                o_stall;
    logic                o_valid;
    logic [HUE_BITS-1:0] o_hue;
    logic [CH_BITS-1:0]  o_saturation;
    logic [CH_BITS-1:0]  o_brightness;

    t_hsv_word expected_hsv[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        idling_on      = 1'b1;

    rgb_to_hsv_converter_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Integer division in SystemVerilog truncates toward zero, which is the
    // rounding the hue quotient needs for negative differences.
    function automatic t_hsv_word predict_hsv(input logic [CH_BITS-1:0] r, g, b);
        int        rv, gv, bv, mx, mn, delta, diff, hue;
        t_sector   sector;
        t_hsv_word w;
        rv = r;
        gv = g;
        bv = b;
        mx = rv;
        mn = rv;
        if (gv > mx) mx = gv;
        if (bv > mx) mx = bv;
        if (gv < mn) mn = gv;
        if (bv < mn) mn = bv;
        delta = mx - mn;
        w.val = mx[CH_BITS-1:0];
        w.sat = '0;
        if (mx != 0) begin
            w.sat = CH_BITS'((CH_FULL * delta) / mx);
        end
        hue = 0;
        if (delta != 0) begin
            // Red wins a tie for the maximum, then green.
            if (rv == mx) begin
                sector = SEC_RED;
                diff = gv - bv;
            end else if (gv == mx) begin
                sector = SEC_GREEN;
                diff = bv - rv;
            end else begin
                sector = SEC_BLUE;
                diff = rv - gv;
            end
            case (sector)
                SEC_RED:   hue = 0;
                SEC_GREEN: hue = 2 * HUE_STEP;
                default:   hue = 4 * HUE_STEP;
            endcase
            hue = hue + (diff * HUE_STEP) / delta;
            if (hue < 0) hue = hue + HUE_TURN;
        end
        w.hue = hue[HUE_BITS-1:0];
        return w;
    endfunction

    // Sends one pixel word and records its prediction once it is taken.
    task automatic send_pixel(input int r, input int g, input int b);
        @(negedge i_clk);
        while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r[CH_BITS-1:0];
        i_green <= g[CH_BITS-1:0];
        i_blue  <= b[CH_BITS-1:0];
        do @(posedge i_clk); while (o_stall);
        expected_hsv.push_back(predict_hsv(r[CH_BITS-1:0], g[CH_BITS-1:0], b[CH_BITS-1:0]));
    endtask

    // Black, white, greys, primaries, every kind of tie and some truncation cases.
    task automatic test_directed_corners();
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(128, 128, 128);
        send_pixel(1, 1, 1);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(255, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(255, 0, 255);
        send_pixel(255, 255, 254);
        send_pixel(255, 0, 1);
        send_pixel(7, 3, 5);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 0);
        send_pixel(0, 0, 1);
        send_pixel(255, 254, 0);
        send_pixel(254, 255, 0);
        send_pixel(1, 0, 255);
        send_pixel(128, 255, 127);
        send_pixel(170, 85, 84);
        send_pixel(3, 254, 253);
    endtask

    // Uniform pixels mixed with pixels built from the channel extremes.
    task automatic test_random_pixels();
        int ch[3];
        repeat (1200) begin
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(3) != 0) begin
                    ch[k] = $urandom_range(CH_FULL);
                end else begin
                    case ($urandom_range(4))
                        0:       ch[k] = 0;
                        1:       ch[k] = 1;
                        2:       ch[k] = CH_FULL - 1;
                        3:       ch[k] = CH_FULL;
                        default: ch[k] = $urandom_range(CH_FULL);
                    endcase
                end
            end
            send_pixel(ch[0], ch[1], ch[2]);
        end
    endtask

    // Two channels sharing one value, and pixels within a few steps of grey.
    task automatic test_ties_and_near_grey();
        int ch[3];
        int base;
        int other;
        repeat (400) begin
            base = $urandom_range(CH_FULL);
            if ($urandom_range(1) == 0) begin
                other = $urandom_range(CH_FULL);
                case ($urandom_range(2))
                    0:       send_pixel(base, base, other);
                    1:       send_pixel(base, other, base);
                    default: send_pixel(other, base, base);
                endcase
            end else begin
                for (int k = 0; k < 3; k++) begin
                    ch[k] = base + int'($urandom_range(4)) - 2;
                    if (ch[k] < 0) ch[k] = 0;
                    if (ch[k] > CH_FULL) ch[k] = CH_FULL;
                end
                send_pixel(ch[0], ch[1], ch[2]);
            end
        end
    endtask

    // A long run with neither side idling, so the pipeline stays full.
    task automatic test_streaming_burst();
        idling_on = 1'b0;
        repeat (200) begin
            send_pixel($urandom_range(CH_FULL), $urandom_range(CH_FULL),
                       $urandom_range(CH_FULL));
        end
        idling_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        i_stall <= idling_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        t_hsv_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hsv.size() == 0) begin
                $display("%0t: result word with no pixel pending: hue %0d sat %0d val %0d",
                         $time, o_hue, o_saturation, o_brightness);
                mismatch_count++;
            end else begin
                want = expected_hsv.pop_front();
                if (o_hue !== want.hue) begin
                    $display("%0t: hue expected %0d actual %0d", $time, want.hue, o_hue);
                    mismatch_count++;
                end
                if (o_saturation !== want.sat) begin
                    $display("%0t: saturation expected %0d actual %0d",
                             $time, want.sat, o_saturation);
                    mismatch_count++;
                end
                if (o_brightness !== want.val) begin
                    $display("%0t: brightness expected %0d actual %0d",
                             $time, want.val, o_brightness);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_to_hsv_converter_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        test_random_pixels();
        test_ties_and_near_grey();
        test_streaming_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_hsv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_hsv.size() == 0) begin
            $display("rgb_to_hsv_converter_unit verification clean");
        end else begin
            $display("rgb_to_hsv_converter_unit verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/r2h_pkg.sv
rtl/core/r2h_front.sv
rtl/core/r2h_queue.sv
rtl/core/r2h_div.sv
rtl/core/r2h_back.sv
rtl/core/rgb_to_hsv_converter_unit.sv
tb/testbench.sv
